// ===== src/cat_pkg.sv =====
package cat_pkg;

  typedef enum logic [2:0] {
    KIND_SEP     = 3'd0,
    KIND_OPEN    = 3'd1,
    KIND_FIRST   = 3'd2,
    KIND_BYTE    = 3'd3,
    KIND_CLOSE   = 3'd4,
    KIND_IGNORED = 3'd5
  } kind_t;

  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  typedef struct packed {
    kind_t       byte_kind;
    logic [3:0]  token_index;
    logic [4:0]  tokens_so_far;
    logic        overflow;
    logic        line_done;
  } result_t;

endpackage

// ===== src/command_argument_tokenizer.sv =====
// Channel  Ports                                    Direction
// in       in_valid, in_stall, in_char_in,          word in
//          in_last_byte
// out      out_valid, out_stall, out_byte_kind,     word out
//          out_token_index, out_tokens_so_far,
//          out_overflow, out_line_done
//
// One word is accepted per cycle while the output is not stalled; a result
// passes an input register and then a result register before it appears.
// The scanner state updates as a word moves between the two.
// Reset is synchronous and active low and empties both registers.
// A stall on the output holds the result; the input stalls only when both
// registers are full.
module command_argument_tokenizer #(
  parameter int MAX_ARGS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_byte_kind,
  output logic [3:0] out_token_index,
  output logic [4:0] out_tokens_so_far,
  output logic       out_overflow,
  output logic       out_line_done
);
  import cat_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;
  logic       out_valid_r;
  result_t    out_res_r;
  result_t    res;
  logic       out_ready;
  logic       advance;
  logic       in_take;

  assign out_ready = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  cat_core #(
    .MAX_ARGS (MAX_ARGS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .char_in   (s1_char_r),
    .last_byte (s1_last_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char_r <= in_char_in;
      s1_last_r <= in_last_byte;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_kind     = out_res_r.byte_kind;
  assign out_token_index   = out_res_r.token_index;
  assign out_tokens_so_far = out_res_r.tokens_so_far;
  assign out_overflow      = out_res_r.overflow;
  assign out_line_done     = out_res_r.line_done;

endmodule

// ===== src/cat_core.sv =====
module cat_core #(
  parameter int MAX_ARGS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        char_in,
  input  logic              last_byte,
  output cat_pkg::result_t  res
);
  import cat_pkg::*;

  localparam int CW = $clog2(MAX_ARGS + 1);
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ARGS);

  typedef enum logic [1:0] {
    MODE_BETWEEN,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_ESCAPE
  } mode_t;

  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          stopped_r, stopped_nxt;

  logic          is_sep, is_quote, is_bslash;
  kind_t         kind;
  logic [CW-1:0] idx;
  logic [CW+4:0] idx_ext, count_ext;

  assign is_sep    = (char_in == CHAR_SPACE) || (char_in == CHAR_TAB);
  assign is_quote  = (char_in == CHAR_QUOTE);
  assign is_bslash = (char_in == CHAR_BSLASH);

  always_comb begin
    mode_nxt    = mode_r;
    count_nxt   = count_r;
    stopped_nxt = stopped_r;
    kind        = KIND_IGNORED;
    idx         = '0;
    if (stopped_r) begin
      kind = KIND_IGNORED;
    end else if (mode_r == MODE_PLAIN && !is_sep) begin
      kind = KIND_BYTE;
      idx  = count_r - 1'b1;
    end else if (mode_r == MODE_QUOTED || mode_r == MODE_ESCAPE) begin
      idx = count_r - 1'b1;
      if (is_quote && mode_r == MODE_QUOTED) begin
        kind     = KIND_CLOSE;
        mode_nxt = MODE_BETWEEN;
      end else begin
        kind     = KIND_BYTE;
        mode_nxt = (is_bslash && !is_quote) ? MODE_ESCAPE : MODE_QUOTED;
      end
    end else if (is_sep) begin
      kind     = KIND_SEP;
      mode_nxt = MODE_BETWEEN;
    end else if (count_r >= MaxCount) begin
      kind        = KIND_IGNORED;
      stopped_nxt = 1'b1;
    end else begin
      idx       = count_r;
      count_nxt = count_r + 1'b1;
      if (is_quote) begin
        kind     = KIND_OPEN;
        mode_nxt = MODE_QUOTED;
      end else begin
        kind     = KIND_FIRST;
        mode_nxt = MODE_PLAIN;
      end
    end
  end

  assign idx_ext   = {5'd0, idx};
  assign count_ext = {5'd0, count_nxt};

  always_comb begin
    res.byte_kind     = kind;
    res.token_index   = idx_ext[3:0];
    res.tokens_so_far = count_ext[4:0];
    res.overflow      = stopped_nxt;
    res.line_done     = last_byte;
  end

  // The end of a line puts the scanner back to its reset state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BETWEEN;
      count_r   <= '0;
      stopped_r <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        mode_r    <= MODE_BETWEEN;
        count_r   <= '0;
        stopped_r <= 1'b0;
      end else begin
        mode_r    <= mode_nxt;
        count_r   <= count_nxt;
        stopped_r <= stopped_nxt;
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import cat_pkg::*;

  localparam int unsigned ARG_LIMIT = 16;
  localparam int unsigned USEFUL_WORDS = 1750;

  typedef enum logic [1:0] {
    SCAN_GAP,
    SCAN_PLAIN,
    SCAN_QUOTED,
    SCAN_ESCAPED
  } scan_t;

  class tokenizer_scoreboard;
    result_t expected_q[$];
    scan_t mode;
    int unsigned token_count;
    bit stopped;
    int unsigned arg_limit;
    int errors;
    int unsigned accepted_words;

    function new(int unsigned limit);
      arg_limit = limit;
      mode = SCAN_GAP;
      token_count = 0;
      stopped = 0;
      errors = 0;
      accepted_words = 0;
    endfunction

    function void note_word(logic [7:0] c, logic last);
      result_t r;
      kind_t kind;
      int unsigned idx;
      bit is_sep;
      bit is_quote;
      bit is_bslash;
      is_sep = (c == CHAR_SPACE) || (c == CHAR_TAB);
      is_quote = (c == CHAR_QUOTE);
      is_bslash = (c == CHAR_BSLASH);
      kind = KIND_IGNORED;
      idx = 0;
      if (stopped) begin
        kind = KIND_IGNORED;
      end else if (mode == SCAN_PLAIN && !is_sep) begin
        kind = KIND_BYTE;
        idx = token_count - 1;
      end else if (mode == SCAN_QUOTED || mode == SCAN_ESCAPED) begin
        idx = token_count - 1;
        if (is_quote && mode == SCAN_QUOTED) begin
          kind = KIND_CLOSE;
          mode = SCAN_GAP;
        end else begin
          kind = KIND_BYTE;
          mode = (is_bslash && !is_quote) ? SCAN_ESCAPED : SCAN_QUOTED;
        end
      end else if (is_sep) begin
        kind = KIND_SEP;
        mode = SCAN_GAP;
      end else if (token_count >= arg_limit) begin
        kind = KIND_IGNORED;
        stopped = 1;
      end else begin
        idx = token_count;
        token_count++;
        if (is_quote) begin
          kind = KIND_OPEN;
          mode = SCAN_QUOTED;
        end else begin
          kind = KIND_FIRST;
          mode = SCAN_PLAIN;
        end
      end
      r.byte_kind = kind;
      r.token_index = idx[3:0];
      r.tokens_so_far = token_count[4:0];
      r.overflow = stopped;
      r.line_done = last;
      expected_q.push_back(r);
      accepted_words++;
      if (last) begin
        mode = SCAN_GAP;
        token_count = 0;
        stopped = 0;
      end
    endfunction

    function void match_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with no word pending, expected none actual kind %0d",
                 $time, got.byte_kind);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      match_field("byte_kind", want.byte_kind, got.byte_kind);
      match_field("token_index", want.token_index, got.token_index);
      match_field("tokens_so_far", want.tokens_so_far, got.tokens_so_far);
      match_field("overflow", want.overflow, got.overflow);
      match_field("line_done", want.line_done, got.line_done);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_in;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_byte_kind;
  logic [3:0] out_token_index;
  logic [4:0] out_tokens_so_far;
  logic       out_overflow;
  logic       out_line_done;

  tokenizer_scoreboard sb;
  logic [7:0] line_q[$];
  bit calm;

  command_argument_tokenizer #(
    .MAX_ARGS(ARG_LIMIT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_in(in_char_in),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte_kind(out_byte_kind),
    .out_token_index(out_token_index),
    .out_tokens_so_far(out_tokens_so_far),
    .out_overflow(out_overflow),
    .out_line_done(out_line_done)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("CHECK FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_word(in_char_in, in_last_byte);
      if (out_valid && !out_stall) begin
        sb.check_result('{kind_t'(out_byte_kind), out_token_index, out_tokens_so_far,
                          out_overflow, out_line_done});
      end
    end
  end

  initial begin
    int r;
    int len;
    out_stall <= 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
        out_stall <= 1'b0;
        len = $urandom_range(1, 12);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else begin
        out_stall <= 1'b1;
        len = $urandom_range(8, 40);
      end
      repeat (len) @(posedge clk);
    end
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 15))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      2: return CHAR_QUOTE;
      3: return CHAR_BSLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] plain_byte(bit first);
    logic [7:0] b;
    do b = pick_byte();
    while (b == CHAR_SPACE || b == CHAR_TAB || (first && b == CHAR_QUOTE));
    return b;
  endfunction

  task automatic send_word(logic [7:0] c, logic last);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    in_last_byte <= last;
    do @(posedge clk);
    while (in_stall);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_word(line_q[i], i == line_q.size() - 1);
  endtask

  task automatic add_seps();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) line_q.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
  endtask

  task automatic build_line();
    int sel;
    int ntok;
    int len;
    int cut;
    bit prev_quoted;
    logic [7:0] b;
    line_q.delete();
    sel = $urandom_range(0, 9);
    prev_quoted = 0;
    if (sel == 7 || sel == 8) begin
      len = $urandom_range(1, 24);
      repeat (len) line_q.push_back(pick_byte());
    end else begin
      ntok = (sel == 9) ? $urandom_range(15, 22) : $urandom_range(0, 6);
      if ($urandom_range(0, 2) == 0) add_seps();
      for (int i = 0; i < ntok; i++) begin
        if (i > 0 && !(prev_quoted && $urandom_range(0, 3) == 0)) add_seps();
        if ($urandom_range(0, 2) == 0) begin
          line_q.push_back(CHAR_QUOTE);
          len = $urandom_range(0, 6);
          repeat (len) begin
            b = pick_byte();
            if (b == CHAR_QUOTE) line_q.push_back(CHAR_BSLASH);
            line_q.push_back(b);
          end
          line_q.push_back(CHAR_QUOTE);
          prev_quoted = 1;
        end else begin
          line_q.push_back(plain_byte(1));
          len = $urandom_range(0, 6);
          repeat (len) line_q.push_back(plain_byte(0));
          prev_quoted = 0;
        end
      end
      if ($urandom_range(0, 2) == 0) add_seps();
      if (sel == 6 && line_q.size() > 1) begin
        cut = $urandom_range(1, line_q.size() - 1);
        while (line_q.size() > cut) void'(line_q.pop_back());
      end
    end
    if (line_q.size() == 0) line_q.push_back("a");
  endtask

  initial begin
    sb = new(ARG_LIMIT);
    calm = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_char_in <= 8'h00;
    in_last_byte <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Separators around extreme bytes, a quote inside a plain token, a backslash
    // before a quote and before a plain byte in quotes, a token opened right
    // after a closing quote, and a line that ends inside quotes.
    line_q = '{8'h00, CHAR_SPACE, 8'hFF, CHAR_TAB, CHAR_TAB, "a", CHAR_QUOTE,
               CHAR_SPACE, CHAR_QUOTE, "b", CHAR_BSLASH, CHAR_QUOTE, CHAR_BSLASH,
               "c", CHAR_QUOTE, CHAR_QUOTE, "x"};
    send_line();
    line_q = '{"z"};
    send_line();
    line_q = '{CHAR_QUOTE, CHAR_BSLASH};
    send_line();

    while (sb.accepted_words < USEFUL_WORDS) begin
      calm = ($urandom_range(0, 7) == 0);
      build_line();
      send_line();
    end
    calm = 0;
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
